FILE: hdl/knn_squared_distance_stream_assert.svh
// Assertion macros for the streaming squared-distance block.
// Included by the top level; needs nothing else.
`ifndef KNN_SQUARED_DISTANCE_STREAM_ASSERT_SVH
`define KNN_SQUARED_DISTANCE_STREAM_ASSERT_SVH

// check that a condition holds at every clock edge out of reset
`define KNN_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("knn: invariant violated");

// check that a condition implies another in the same cycle
`define KNN_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("knn: implication violated");

// check that a condition is followed by another a fixed number of cycles later
`define KNN_ASSERT_DELAYED(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("knn: delayed response missing");

`endif

FILE: hdl/knn_pkg.sv
// Shared types and constants of the streaming squared-distance block.
// No dependencies.
package knn_pkg;

   localparam int VECTOR_LEN_DEF = 4096;
   localparam int TAG_BYTES_DEF  = 64;

   localparam int IDX_W   = 12;
   localparam int SUM_W   = 31;
   localparam int CNT_W   = 20;
   localparam int DIFF_W  = 10;
   localparam int SQ_W    = 17;

   localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [7:0]       DIGIT_ZERO = 8'd48;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_RECORD = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [IDX_W-1:0]   query_index;
      logic signed [7:0]  query_value;
      logic [7:0]         record_byte;
   } req_word_type;

   typedef struct packed {
      logic [SUM_W-1:0] distance;
      logic [CNT_W-1:0] record_number;
   } rsp_word_type;

   // control that travels with a record byte down the pipeline
   typedef struct packed {
      logic valid;
      logic vec;
      logic last;
   } stage_ctl_type;

endpackage

FILE: hdl/knn_qmem.sv
// Query vector store: one write port, one registered read port.
// Uses no package items.
module knn_qmem #(
   parameter  int VECTOR_LEN = 4096,
   localparam int AddrW      = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AddrW-1:0]         wr_addr,
   input  logic signed [7:0]        wr_data,
   input  logic                     rd_en,
   input  logic [AddrW-1:0]         rd_addr,
   output logic signed [7:0]        rd_data
);
   logic signed [7:0] mem [VECTOR_LEN];
   logic signed [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/knn_mac.sv
// Square-and-accumulate datapath: difference, square, saturating sum, record count.
// Depends on knn_pkg.
module knn_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  knn_pkg::stage_ctl_type  s1_ctl,
   input  logic [7:0]              s1_byte,
   input  logic signed [7:0]       q_data,
   output logic                    push_valid,
   output knn_pkg::rsp_word_type   push_word
);
   logic signed [knn_pkg::DIFF_W-1:0]   diff;
   logic signed [2*knn_pkg::DIFF_W-1:0] prod;
   logic [knn_pkg::SQ_W-1:0]            sq_in;
   logic [knn_pkg::SQ_W-1:0]            sq_ff;
   knn_pkg::stage_ctl_type              s2_ctl_ff;
   logic [knn_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [knn_pkg::SUM_W-1:0]           sum_sat;
   logic [knn_pkg::SUM_W:0]             sum_wide;
   logic [knn_pkg::CNT_W-1:0]           rec_cnt_ff, rec_cnt_in;

   // digit = byte - '0'; diff = query - digit
   always_comb begin
      diff = {{(knn_pkg::DIFF_W - 8){q_data[7]}}, q_data}
           - ($signed({2'b00, s1_byte}) - $signed({2'b00, knn_pkg::DIGIT_ZERO}));
      prod  = diff * diff;
      sq_in = prod[knn_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl;
      end
   end

   always_comb begin
      sum_wide = {1'b0, sum_ff};
      if (s2_ctl_ff.valid && s2_ctl_ff.vec) begin
         sum_wide = {1'b0, sum_ff} + (knn_pkg::SUM_W + 1)'(sq_ff);
      end
      sum_sat = (sum_wide > {1'b0, knn_pkg::SUM_MAX}) ? knn_pkg::SUM_MAX
                                                      : sum_wide[knn_pkg::SUM_W-1:0];
      push_valid = s2_ctl_ff.valid && s2_ctl_ff.last;
      push_word.distance      = sum_sat;
      push_word.record_number = rec_cnt_ff;
      sum_in     = sum_ff;
      rec_cnt_in = rec_cnt_ff;
      if (s2_ctl_ff.valid) begin
         sum_in = sum_sat;
      end
      if (push_valid) begin
         sum_in     = '0;
         rec_cnt_in = rec_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         rec_cnt_ff <= '0;
      end else begin
         sum_ff     <= sum_in;
         rec_cnt_ff <= rec_cnt_in;
      end
   end

endmodule

FILE: hdl/knn_ofifo.sv
// Small result queue between the accumulator and the result channel.
// Depends on knn_pkg.
module knn_ofifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push_valid,
   input  knn_pkg::rsp_word_type          push_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output knn_pkg::rsp_word_type          rsp_word,
   output logic [knn_pkg::FIFO_CNT_W-1:0] count
);
   knn_pkg::rsp_word_type                 slot_ff [knn_pkg::FIFO_DEPTH];
   logic [knn_pkg::FIFO_PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [knn_pkg::FIFO_CNT_W-1:0]        count_ff;
   logic                                  pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + knn_pkg::FIFO_CNT_W'(push_valid)
                             - knn_pkg::FIFO_CNT_W'(pop);
      end
   end

endmodule

FILE: hdl/knn_squared_distance_stream.sv
// Streaming squared distance of records to a stored query vector.
// Throughput: one word per cycle, query loads and record bytes alike; input
// stalls only while four results sit in the result queue or the pipeline.
// Path of a record's last byte to rsp: store read at the accepting edge, square
// register, then accumulate and push into the result queue.
// Reset (synchronous): clears position, sum, record number, pipeline and queue.
`include "knn_squared_distance_stream_assert.svh"
module knn_squared_distance_stream #(
   parameter int VECTOR_LEN = knn_pkg::VECTOR_LEN_DEF,
   parameter int TAG_BYTES  = knn_pkg::TAG_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  knn_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output knn_pkg::rsp_word_type rsp_word
);
   localparam int RecordLen = TAG_BYTES + VECTOR_LEN;
   localparam int PosW      = (RecordLen > 1) ? $clog2(RecordLen) : 1;
   localparam int AddrW     = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
   localparam logic [PosW-1:0] PosLast = PosW'(RecordLen - 1);
   localparam logic [PosW-1:0] PosTag  = PosW'(TAG_BYTES);
   localparam logic [knn_pkg::FIFO_CNT_W-1:0] QueueDepth =
      knn_pkg::FIFO_CNT_W'(knn_pkg::FIFO_DEPTH);
   localparam logic [knn_pkg::FIFO_CNT_W:0] CreditDepth =
      (knn_pkg::FIFO_CNT_W + 1)'(knn_pkg::FIFO_DEPTH);

   logic                             accept, accept_rec, load_en;
   logic                             is_vec, is_last;
   logic [PosW-1:0]                  pos_ff, pos_in;
   logic [PosW-1:0]                  elem;
   knn_pkg::stage_ctl_type           s1_ctl_ff, s1_ctl_in;
   logic [7:0]                       s1_byte_ff;
   logic signed [7:0]                q_data;
   logic                             push_valid;
   knn_pkg::rsp_word_type            push_word;
   logic [knn_pkg::FIFO_CNT_W-1:0]   fifo_count;
   logic [knn_pkg::FIFO_CNT_W:0]     inflight;

   // Reserve a queue slot for every result already in the pipeline so a
   // finished record never finds the queue full; ready does not look at rsp_ready.
   assign inflight  = (knn_pkg::FIFO_CNT_W + 1)'(fifo_count)
                    + (knn_pkg::FIFO_CNT_W + 1)'(s1_ctl_ff.last)
                    + (knn_pkg::FIFO_CNT_W + 1)'(push_valid);
   assign req_ready = (inflight < CreditDepth);

   assign accept     = req_valid && req_ready;
   assign accept_rec = accept && (req_word.opcode == knn_pkg::OP_RECORD);
   // drop loads beyond the vector length
   assign load_en    = accept && (req_word.opcode == knn_pkg::OP_LOAD)
                    && (32'(req_word.query_index) < 32'(VECTOR_LEN));

   // Position within the record: tag bytes first, then vector elements.
   assign is_vec  = (pos_ff >= PosTag);
   assign is_last = (pos_ff == PosLast);
   assign elem    = pos_ff - PosTag;

   always_comb begin
      pos_in = pos_ff;
      if (accept_rec) begin
         pos_in = is_last ? '0 : pos_ff + 1'b1;
      end
      s1_ctl_in.valid = accept_rec;
      s1_ctl_in.vec   = accept_rec && is_vec;
      s1_ctl_in.last  = accept_rec && is_last;
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= req_word.record_byte;
      if (reset) begin
         pos_ff    <= '0;
         s1_ctl_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // A load and a later byte never touch the store in the same cycle, so a
   // byte always reads the value left by every load accepted before it.
   knn_qmem #(
      .VECTOR_LEN (VECTOR_LEN)
   ) u_qmem (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AddrW'(req_word.query_index)),
      .wr_data (req_word.query_value),
      .rd_en   (s1_ctl_in.vec),
      .rd_addr (AddrW'(elem)),
      .rd_data (q_data)
   );

   knn_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .s1_ctl     (s1_ctl_ff),
      .s1_byte    (s1_byte_ff),
      .q_data     (q_data),
      .push_valid (push_valid),
      .push_word  (push_word)
   );

   knn_ofifo u_ofifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .count      (fifo_count)
   );

   // queue never receives a result while full
   `KNN_ASSERT_IMPLIES(a_push_room, clock, reset, push_valid, fifo_count < QueueDepth)
   // queued plus in-flight results never exceed the queue depth
   `KNN_ASSERT_ALWAYS(a_credit, clock, reset, inflight <= CreditDepth)
   // a record's last byte reaches the queue through the s1 and s2 control registers
   `KNN_ASSERT_DELAYED(a_last_push, clock, reset, accept_rec && is_last, 2, push_valid)

endmodule

FILE: sim/knn_squared_distance_stream_tb.sv
// Self-checking testbench for knn_squared_distance_stream: loads query vectors,
// streams whole records and checks every distance against a local predictor.
// Depends on knn_pkg and the RTL of knn_squared_distance_stream.
module knn_squared_distance_stream_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VEC_LEN = knn_pkg::VECTOR_LEN_DEF;
   localparam int TAG_LEN = knn_pkg::TAG_BYTES_DEF;
   localparam int REC_LEN = TAG_LEN + VEC_LEN;

   localparam int     RECORDS_PER_PHASE = 12;
   localparam int     PRESSURE_CYCLES   = 25000;
   localparam int     DRAIN_CYCLES      = 16;
   localparam longint CYCLE_LIMIT       = 3000000;

   // directed script: what each row streams into the block
   typedef enum logic [1:0] {
      ROW_FILL,    // load every query element with one value
      ROW_LOAD,    // load a single query element
      ROW_RECORD,  // one record: constant tag byte, constant vector byte
      ROW_RIPPLE   // as ROW_RECORD, but rewrite each element just before it is used
   } row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [knn_pkg::IDX_W-1:0]     index;
      logic signed [7:0]             value;
      logic [7:0]                    tag;
      logic [7:0]                    vec;
      logic                          typed;     // distance below is the expected one
      logic [knn_pkg::SUM_W-1:0]     distance;
   } row_type;

   localparam int SCRIPT_LEN = 11;
   localparam row_type SCRIPT [SCRIPT_LEN] = '{
      // all-zero query against all '0' digits: distance zero
      '{ROW_FILL,   0,    0,    8'h00, 8'h00, 1'b0, 0},
      '{ROW_RECORD, 0,    0,    8'h00, 8'h30, 1'b1, 0},
      // largest positive query against byte 0x00: (127 + 48)^2 per element
      '{ROW_FILL,   0,    127,  8'h00, 8'h00, 1'b0, 0},
      '{ROW_RECORD, 0,    0,    8'hFF, 8'h00, 1'b1, 125440000},
      // most negative query against byte 0xFF: (-128 - 207)^2 per element
      '{ROW_FILL,   0,    -128, 8'h00, 8'h00, 1'b0, 0},
      '{ROW_RECORD, 0,    0,    8'hA5, 8'hFF, 1'b1, 459673600},
      // single loads at both ends and in the middle of the store
      '{ROW_LOAD,   0,    127,  8'h00, 8'h00, 1'b0, 0},
      '{ROW_LOAD,   4095, -128, 8'h00, 8'h00, 1'b0, 0},
      '{ROW_LOAD,   2048, 85,   8'h00, 8'h00, 1'b0, 0},
      '{ROW_RECORD, 0,    0,    8'h5A, 8'h39, 1'b0, 0},
      // loads woven into a record, each landing right before its element
      '{ROW_RIPPLE, 0,    0,    8'h30, 8'h35, 1'b0, 0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   knn_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   knn_pkg::rsp_word_type rsp_word;

   // predictor state: shadow of the query store, position, sum and record number
   logic signed [7:0]         query_shadow [VEC_LEN];
   int unsigned               stream_pos;
   logic [knn_pkg::SUM_W-1:0] sum_shadow;
   logic [knn_pkg::CNT_W-1:0] record_shadow;

   knn_pkg::rsp_word_type     distance_q [$];   // distances still owed by the block
   logic                      typed_on = 1'b0;
   logic [knn_pkg::SUM_W-1:0] typed_distance;

   int     send_idle_pct;
   int     recv_idle_pct;
   bit     pressure_go = 1'b0;
   bit     rsp_hold = 1'b0;
   int     error_count = 0;
   longint cycle_count = 0;

   knn_squared_distance_stream DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t ns: MISMATCH on %s: got %0d, want %0d", $time, field, got, want);
   endtask

   // Advance the shadow state by one accepted word; return 1 when a record
   // finishes, with its distance and number in done.
   function automatic bit advance_distance(input knn_pkg::req_word_type w,
                                           output knn_pkg::rsp_word_type done);
      int     digit;
      int     diff;
      longint total;
      done = '0;
      if (w.opcode == knn_pkg::OP_LOAD) begin
         if (w.query_index < VEC_LEN) query_shadow[w.query_index] = w.query_value;
         return 1'b0;
      end
      // skip tag bytes; accumulate vector bytes, clamped at the top of the range
      if (stream_pos >= TAG_LEN && stream_pos - TAG_LEN < VEC_LEN) begin
         digit = int'(w.record_byte) - int'(knn_pkg::DIGIT_ZERO);
         diff  = int'(query_shadow[stream_pos - TAG_LEN]) - digit;
         total = longint'(sum_shadow) + longint'(diff * diff);
         sum_shadow = (total > longint'(knn_pkg::SUM_MAX)) ? knn_pkg::SUM_MAX
                                                           : total[knn_pkg::SUM_W-1:0];
      end
      if (stream_pos + 1 >= REC_LEN) begin
         done.distance      = sum_shadow;
         done.record_number = record_shadow;
         sum_shadow    = '0;
         stream_pos    = 0;
         record_shadow = record_shadow + 1'b1;
         return 1'b1;
      end
      stream_pos++;
      return 1'b0;
   endfunction

   // Predict on every accepted request word, then check every accepted result.
   // Push before pop, so the order of the two in one edge never matters.
   always @(posedge clock) begin : monitor
      knn_pkg::rsp_word_type done;
      knn_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (advance_distance(req_word, done)) begin
               // directed rows with a typed distance replace the prediction
               if (typed_on) done.distance = typed_distance;
               distance_q.push_back(done);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (distance_q.size() == 0) begin
               report_mismatch("unexpected distance", rsp_word.distance, 0);
            end else begin
               want = distance_q.pop_front();
               if (rsp_word.distance !== want.distance)
                  report_mismatch("distance", rsp_word.distance, want.distance);
               if (rsp_word.record_number !== want.record_number)
                  report_mismatch("record_number", rsp_word.record_number,
                                  want.record_number);
            end
         end
      end
   end

   // Receiver: drop ready at random, or hold it low through a pressure stretch.
   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Pressure: hold off the result channel long enough for several records to
   // finish, so the result queue fills and the block must stall its input.
   initial begin : pressure
      wait (pressure_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Watchdog: end the run if it never drains.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one word: idle first at random, then hold valid and payload until
   // the word is taken. Entered and left at a falling edge.
   task automatic send_word(input knn_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Build words with random junk in the fields the block must ignore.
   function automatic knn_pkg::req_word_type load_word(
         input logic [knn_pkg::IDX_W-1:0] index, input logic signed [7:0] value);
      knn_pkg::req_word_type w;
      w.opcode      = knn_pkg::OP_LOAD;
      w.query_index = index;
      w.query_value = value;
      w.record_byte = 8'($urandom_range(255));
      return w;
   endfunction

   function automatic knn_pkg::req_word_type record_word(input logic [7:0] data);
      knn_pkg::req_word_type w;
      w.opcode      = knn_pkg::OP_RECORD;
      w.query_index = knn_pkg::IDX_W'($urandom_range(VEC_LEN - 1));
      w.query_value = 8'($urandom_range(255));
      w.record_byte = data;
      return w;
   endfunction

   task automatic fill_query(input bit scramble, input logic signed [7:0] value);
      int i;
      for (i = 0; i < VEC_LEN; i++)
         send_word(load_word(knn_pkg::IDX_W'(i),
                             scramble ? 8'($urandom_range(255)) : value));
   endtask

   task automatic send_record(input logic [7:0] tag, input logic [7:0] vec,
                              input bit ripple);
      int pos;
      for (pos = 0; pos < REC_LEN; pos++) begin
         if (ripple && pos >= TAG_LEN)
            send_word(load_word(knn_pkg::IDX_W'(pos - TAG_LEN), 8'(pos - TAG_LEN)));
         send_word(record_word(pos < TAG_LEN ? tag : vec));
      end
   endtask

   // Random record: mostly digit vectors, some raw-byte vectors, some records
   // with dense loads. Loads often land next to the element in flight, to hit
   // the store read just before or after it is rewritten.
   task automatic send_random_record();
      int         pos;
      int         style;
      int         load_pct;
      int         target;
      logic [7:0] data;
      style    = $urandom_range(9);
      load_pct = (style == 1) ? 25 : 2;
      for (pos = 0; pos < REC_LEN; pos++) begin
         if ($urandom_range(99) < load_pct) begin
            if (pos >= TAG_LEN && $urandom_range(1) == 0)
               target = (pos - TAG_LEN + VEC_LEN - 1 + $urandom_range(3)) % VEC_LEN;
            else
               target = $urandom_range(VEC_LEN - 1);
            send_word(load_word(knn_pkg::IDX_W'(target), 8'($urandom_range(255))));
         end
         if (pos < TAG_LEN || style == 0 || $urandom_range(9) == 0)
            data = 8'($urandom_range(255));
         else
            data = knn_pkg::DIGIT_ZERO + 8'($urandom_range(9));
         send_word(record_word(data));
      end
      // stray loads between records: no result, just noise
      repeat ($urandom_range(3))
         send_word(load_word(knn_pkg::IDX_W'($urandom_range(VEC_LEN - 1)),
                             8'($urandom_range(255))));
   endtask

   task automatic random_phase();
      fill_query(1'b1, '0);
      repeat (RECORDS_PER_PHASE) send_random_record();
   endtask

   initial begin : stimulus
      int      r;
      row_type row;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      stream_pos    = 0;
      sum_shadow    = '0;
      record_shadow = '0;
      send_idle_pct = 18;
      recv_idle_pct = 81;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed script, light sender idling, heavy receiver idling
      for (r = 0; r < SCRIPT_LEN; r++) begin
         row = SCRIPT[r];
         case (row.kind)
            ROW_FILL: fill_query(1'b0, row.value);
            ROW_LOAD: send_word(load_word(row.index, row.value));
            default: begin
               typed_on       = row.typed;
               typed_distance = row.distance;
               send_record(row.tag, row.vec, row.kind == ROW_RIPPLE);
               typed_on       = 1'b0;
            end
         endcase
      end
      random_phase();

      // swap: heavy sender idling, light receiver idling
      send_idle_pct = 81;
      recv_idle_pct = 18;
      random_phase();

      // full rate both ways, with the long result hold-off on top
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_go   = 1'b1;
      random_phase();
      req_valid <= 1'b0;

      // drain, then give any stray result time to show up
      while (distance_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
